/* rtl/core/uud_pkg.sv */
// Shared constants, result kind codes and helper functions for the uudecode stream decoder.
// No dependencies; the decoder top level imports this package.
package uud_pkg;

    // Width of the running byte counter; the reported total is its low 24 bits.
    localparam int COUNT_BITS = 24;
    localparam int TOTAL_BITS = 24;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TICK = 8'h60;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_N    = 8'h6E;

    // Six-bit value of one encoded character.
    function automatic logic [5:0] sextet(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_TICK;
        return d[5:0];
    endfunction

    // Adds a small amount to the counter, sticking at the top value.
    function automatic t_count sat_add(input t_count a, input logic [2:0] k);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + (COUNT_BITS + 1)'(k);
        return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

endpackage

/* rtl/core/uudecode_stream_decoder_top.sv */
// uudecode stream decoder: one text character in, up to four result items out.
// Depends on uud_pkg for kind codes, character constants and the saturating counter helper.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_ch, i_end_of_file
//  result   out        o_valid / i_stall  o_kind, o_data_byte, o_byte_total, o_last
//
// Each accepted character is decoded in the cycle it arrives; its results (at most three
// bytes and one status) land in the result register and are shown one per cycle unless i_stall holds them.
// A character that causes zero or one result leaves room for the next one in the next cycle;
// a group-closing character that yields more results stalls the input until its last result is taken.
// Reset (synchronous, active low) returns to looking for the begin line and clears the count.
// While the result side stalls, the input side stalls as soon as the result register is full.
module uudecode_stream_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_end_of_file,
    output logic                o_valid,
    input  logic                i_stall,
    output uud_pkg::t_kind      o_kind,
    output logic [7:0]          o_data_byte,
    output logic [uud_pkg::TOTAL_BITS-1:0] o_byte_total,
    output logic                o_last
);
    import uud_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK  = 3'd0,
        PH_MATCH = 3'd1,
        PH_SKIP  = 3'd2,
        PH_START = 3'd3,
        PH_BODY  = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    // Decoder state.
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [5:0]  r_len, n_len;
    logic [6:0]  r_bil, n_bil;
    logic [1:0]  r_fill, n_fill;
    logic [17:0] r_held, n_held;
    t_count      r_total, n_total;

    // Result register: the bundle of results caused by one character.
    logic        r_valid;
    logic [2:0]  r_nres;
    logic [1:0]  r_idx;
    logic [1:0]  r_nbytes;
    logic [7:0]  r_byte0, r_byte1, r_byte2;
    t_kind       r_stat_kind;
    t_count      r_t0;

    logic        acc, take, take_last, out_is_byte, is_last;
    logic        eol, stat, do_flush;
    t_kind       stat_kind;
    logic [17:0] f_held;
    logic [5:0]  f_d, sx;
    logic [6:0]  left;
    logic [1:0]  nb;
    logic [7:0]  fb0, fb1, fb2;
    logic [2:0]  out_off;
    t_count      out_total;

    // Expected letter of "begin" at a given match position.
    function automatic logic [7:0] begin_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd1:    c = CH_E;
            3'd2:    c = CH_G;
            3'd3:    c = CH_I;
            3'd4:    c = CH_N;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // Left-align a partial group so that missing characters read as zero.
    function automatic logic [17:0] align_part(input logic [17:0] h, input logic [1:0] f);
        logic [17:0] r;
        case (f)
            2'd1:    r = {h[5:0], 12'd0};
            2'd2:    r = {h[11:0], 6'd0};
            default: r = h;
        endcase
        return r;
    endfunction

    assign is_last   = ({1'b0, r_idx} + 3'd1) == r_nres;
    assign take      = r_valid && !i_stall;
    assign take_last = take && is_last;
    assign o_stall   = r_valid && !take_last;
    assign acc       = i_valid && !o_stall;

    assign eol = (i_ch == CH_LF) || (i_ch == CH_CR);
    assign sx  = sextet(i_ch);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len     = r_len;
        n_bil     = r_bil;
        n_fill    = r_fill;
        n_held    = r_held;
        do_flush  = 1'b0;
        f_held    = r_held;
        f_d       = 6'd0;
        stat      = 1'b0;
        stat_kind = KIND_DONE;

        unique case (r_phase)
            PH_SEEK: begin
                if (i_ch == CH_NUL) begin
                    stat      = 1'b1;
                    stat_kind = KIND_ERR;
                    n_phase   = PH_DONE;
                end else if (i_ch == CH_B) begin
                    n_phase = PH_MATCH;
                    n_pos   = 3'd1;
                end
            end
            PH_MATCH: begin
                if (i_ch != begin_char(r_pos)) begin
                    stat      = 1'b1;
                    stat_kind = KIND_ERR;
                    n_phase   = PH_DONE;
                end else begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd4) begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (i_ch == CH_NUL) begin
                    stat    = 1'b1;
                    n_phase = PH_DONE;
                end else if (i_ch == CH_LF) begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (eol) begin
                    n_phase = PH_START;
                end else if (i_ch == CH_NUL || i_ch == CH_TICK || i_ch == CH_E) begin
                    stat    = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_len   = sx;
                    n_bil   = 7'd0;
                    n_fill  = 2'd0;
                    n_held  = 18'd0;
                    n_phase = (sx == 6'd0) ? PH_SKIP : PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_ch == CH_NUL || eol) begin
                    // A line end or text end inside a group flushes it zero-filled.
                    if (r_fill != 2'd0) begin
                        do_flush = 1'b1;
                        f_held   = align_part(r_held, r_fill);
                    end
                    if (i_ch == CH_NUL) begin
                        stat    = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = (i_ch == CH_LF) ? PH_START : PH_SKIP;
                    end
                end else if (r_fill == 2'd3) begin
                    do_flush = 1'b1;
                    f_held   = r_held;
                    f_d      = sx;
                    if (({1'b0, r_bil} + 8'd3) >= {2'b00, r_len}) begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_held = {r_held[11:0], sx};
                    n_fill = r_fill + 2'd1;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (i_end_of_file && n_phase != PH_DONE) begin
            stat = 1'b1;
            if (n_phase == PH_SEEK || n_phase == PH_MATCH) begin
                stat_kind = KIND_ERR;
            end else begin
                stat_kind = KIND_DONE;
                // A group closed by this character has already been flushed.
                if (n_phase == PH_BODY && n_fill != 2'd0 && !do_flush) begin
                    do_flush = 1'b1;
                    f_held   = align_part(n_held, n_fill);
                    f_d      = 6'd0;
                end
            end
            n_phase = PH_DONE;
        end

        if (do_flush) begin
            n_bil  = r_bil + 7'd3;
            n_fill = 2'd0;
            n_held = 18'd0;
        end
    end

    // Group decode: three bytes from four sextets, limited by what is left of the line.
    assign left = (r_bil < {1'b0, r_len}) ? ({1'b0, r_len} - r_bil) : 7'd0;
    assign nb   = !do_flush ? 2'd0 : ((left >= 7'd3) ? 2'd3 : left[1:0]);
    assign fb0  = {f_held[17:12], f_held[11:10]};
    assign fb1  = {f_held[9:6], f_held[5:2]};
    assign fb2  = {f_held[1:0], f_d};
    assign n_total = sat_add(r_total, {1'b0, nb});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_pos   <= 3'd0;
            r_len   <= 6'd0;
            r_bil   <= 7'd0;
            r_fill  <= 2'd0;
            r_held  <= 18'd0;
            r_total <= '0;
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_nres  <= 3'd0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_bil   <= n_bil;
                r_fill  <= n_fill;
                r_held  <= n_held;
                r_total <= n_total;
                r_valid <= (nb != 2'd0) || stat;
                r_nres  <= {1'b0, nb} + {2'b00, stat};
                r_idx   <= 2'd0;
            end else if (take) begin
                if (is_last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_nbytes    <= nb;
            r_byte0     <= fb0;
            r_byte1     <= fb1;
            r_byte2     <= fb2;
            r_stat_kind <= stat_kind;
            r_t0        <= r_total;
        end
    end

    // Bytes carry the count including themselves; the status carries the final count.
    assign out_is_byte  = r_idx < r_nbytes;
    assign out_off      = out_is_byte ? ({1'b0, r_idx} + 3'd1) : {1'b0, r_idx};
    assign out_total    = sat_add(r_t0, out_off);

    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = r_byte0;
            2'd1:    o_data_byte = r_byte1;
            default: o_data_byte = r_byte2;
        endcase
        if (!out_is_byte) begin
            o_data_byte = 8'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = out_is_byte ? KIND_BYTE : r_stat_kind;
    assign o_byte_total = TOTAL_BITS'(out_total);
    assign o_last       = is_last;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_nres))
        else $error("result index ran past the bundle");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_BYTE) |-> o_last)
        else $error("status result not marked last");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_phase == PH_DONE) |=> !o_valid)
        else $error("result produced after decoding finished");

    a_no_count_before_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEEK || r_phase == PH_MATCH) |-> (r_total == '0))
        else $error("bytes counted before the begin line");

    a_match_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MATCH) |-> (r_pos >= 3'd1 && r_pos <= 3'd4))
        else $error("begin match position out of range");

endmodule
